>>> design/awslm_pkg.sv
package awslm_pkg;

   localparam int SAMPLE_BITS = 13;
   localparam int SECTIONS    = 3;
   localparam int TALLY_BITS  = 17;
   localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int ZDEPTH      = 2 * SECTIONS;

   localparam int RMS_BITS    = 20;
   localparam int LEVEL_BITS  = 12;
   localparam int COUNT_BITS  = 17;
   localparam int COUNT_MAX   = 131071;

   localparam logic [31:0] DC_KEEP = 32'd16775538;
   localparam logic [15:0] DC_TAKE = 16'd1678;
   localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd3945660;

   localparam logic [1:0] CSR_WIDE_ADC_MODE     = 2'd0;
   localparam logic [1:0] CSR_SLOPE_Q16         = 2'd1;
   localparam logic [1:0] CSR_REF_RMS_CENTI_MV  = 2'd2;
   localparam logic [1:0] CSR_REF_LEVEL_DECI_DB = 2'd3;

   localparam logic [2:0] TAP_B0 = 3'd0;
   localparam logic [2:0] TAP_B1 = 3'd1;
   localparam logic [2:0] TAP_B2 = 3'd2;
   localparam logic [2:0] TAP_A1 = 3'd3;
   localparam logic [2:0] TAP_A2 = 3'd4;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   window_last;
   } awslm_item_type;

   typedef struct packed {
      logic        wide_adc_mode;
      logic [17:0] slope_q16;
      logic [19:0] ref_rms_centi_mv;
      logic [10:0] ref_level_deci_db;
   } awslm_cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DC, ST_X, ST_B0, ST_Y, ST_C1, ST_C3, ST_C2, ST_C4,
      ST_SQ, ST_ACC, ST_DIV, ST_NORM, ST_SQRT, ST_R100, ST_V, ST_CENTI,
      ST_LNORM, ST_LMUL, ST_LSTEP, ST_LNEXT, ST_LVL, ST_LVL2, ST_OUT
   } awslm_state_type;

   function automatic logic signed [31:0] coef(input logic [1:0] sec, input logic [2:0] tap);
      logic signed [31:0] c;
      c = '0;
      case (sec)
         2'd0: begin
            case (tap)
               TAP_B0:  c = 32'sd2219177;
               TAP_B1:  c = -32'sd4438354;
               TAP_B2:  c = 32'sd2219177;
               TAP_A1:  c = -32'sd8321025;
               TAP_A2:  c = 32'sd4126994;
               default: c = '0;
            endcase
         end
         2'd1: begin
            case (tap)
               TAP_B0:  c = 32'sd4194304;
               TAP_B1:  c = -32'sd8388608;
               TAP_B2:  c = 32'sd4194304;
               TAP_A1:  c = -32'sd7153427;
               TAP_A2:  c = 32'sd3003071;
               default: c = '0;
            endcase
         end
         2'd2: begin
            case (tap)
               TAP_B0:  c = 32'sd4194304;
               TAP_B1:  c = 32'sd8388608;
               TAP_B2:  c = 32'sd4194304;
               TAP_A1:  c = 32'sd3445889;
               TAP_A2:  c = 32'sd707755;
               default: c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
      logic signed [39:0] r;
      if (v > 48'sd549755813887) begin
         r = 40'sh7F_FFFF_FFFF;
      end else if (v < -48'sd549755813888) begin
         r = 40'sh80_0000_0000;
      end else begin
         r = v[39:0];
      end
      return r;
   endfunction

endpackage

>>> design/awslm_front.sv
module awslm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  awslm_pkg::awslm_item_type req_item,
   output logic                     q_valid,
   output awslm_pkg::awslm_item_type q_item,
   input  logic                     q_pop
);
   import awslm_pkg::*;

   awslm_item_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           push;

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + (push ? 2'd1 : 2'd0) - (q_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

>>> design/awslm_back.sv
module awslm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  awslm_pkg::awslm_cfg_type  cfg,
   input  logic                      q_valid,
   input  awslm_pkg::awslm_item_type q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [19:0]               rsp_rms_centi_mv,
   output logic signed [11:0]        rsp_level_deci_db,
   output logic [16:0]               rsp_window_count
);
   import awslm_pkg::*;

   awslm_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] raw_ff, raw_in;
   logic                   last_ff, last_in;
   logic [31:0]            dc_ff, dc_in;
   logic signed [39:0]     x_ff, x_in;
   logic signed [39:0]     y_ff, y_in;
   logic signed [47:0]     acc_ff, acc_in;
   logic signed [39:0]     z1n_ff, z1n_in;
   logic signed [39:0]     z_ff [ZDEPTH];
   logic signed [39:0]     z_in [ZDEPTH];
   logic [SEC_W-1:0]       sec_ff, sec_in;
   logic signed [72:0]     prod_ff;
   logic signed [40:0]     mul_a;
   logic signed [31:0]     mul_b;
   logic [63:0]            sum_ff, sum_in;
   logic [TALLY_BITS-1:0]  tally_ff, tally_in;
   logic [63:0]            num_ff, num_in;
   logic [TALLY_BITS-1:0]  den_ff, den_in;
   logic [TALLY_BITS-1:0]  rem_ff, rem_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [3:0]             e_ff, e_in;
   logic [63:0]            root_ff, root_in;
   logic [63:0]            bit_ff, bit_in;
   logic [63:0]            v_ff, v_in;
   logic [63:0]            lv_ff, lv_in;
   logic [30:0]            m_ff, m_in;
   logic [15:0]            f_ff, f_in;
   logic [5:0]             lexp_ff, lexp_in;
   logic                   pass_ff, pass_in;
   logic signed [24:0]     lacc_ff, lacc_in;
   logic [19:0]            rms_ff, rms_in;
   logic signed [11:0]     level_ff, level_in;
   logic [16:0]            count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [19:0]            out_rms_ff, out_rms_in;
   logic signed [11:0]     out_level_ff, out_level_in;
   logic [16:0]            out_count_ff, out_count_in;

   logic signed [72:0]     prod_rnd;
   logic signed [47:0]     q22;
   logic signed [47:0]     z0_ext, z1_ext;
   logic [56:0]            dc_sum;
   logic [31:0]            dc_new;
   logic signed [47:0]     x_full;
   logic signed [40:0]     y4;
   logic signed [40:0]     y4_mag;
   logic [64:0]            sum_wide;
   logic [TALLY_BITS-1:0]  tally_new;
   logic [63:0]            sum_new;
   logic [31:0]            tally_wide;
   logic [TALLY_BITS:0]    div_t;
   logic                   div_ge;
   logic [63:0]            root_bit;
   logic [40:0]            r100;
   logic [63:0]            centi;
   logic [63:0]            mm;
   logic [21:0]            logval;
   logic signed [72:0]     lvl_rnd;
   logic signed [19:0]     lvl;
   logic [5:0]             e_shift;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rms_centi_mv  = out_rms_ff;
   assign rsp_level_deci_db = out_level_ff;
   assign rsp_window_count  = out_count_ff;

   assign prod_rnd = (prod_ff + 73'sd2097152) >>> 22;
   assign q22      = prod_rnd[47:0];
   assign z0_ext   = 48'(z_ff[0]);
   assign z1_ext   = 48'(z_ff[1]);

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      last_in      = last_ff;
      dc_in        = dc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      z1n_in       = z1n_ff;
      z_in         = z_ff;
      sec_in       = sec_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      e_in         = e_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      v_in         = v_ff;
      lv_in        = lv_ff;
      m_in         = m_ff;
      f_in         = f_ff;
      lexp_in      = lexp_ff;
      pass_in      = pass_ff;
      lacc_in      = lacc_ff;
      rms_in       = rms_ff;
      level_in     = level_ff;
      count_in     = count_ff;
      out_rms_in   = out_rms_ff;
      out_level_in = out_level_ff;
      out_count_in = out_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      dc_sum = 57'(prod_ff[56:0]) + ((57'(raw_ff) * 57'(DC_TAKE)) << 16) + 57'(64'd1 << 23);
      dc_new = dc_sum[55:24];
      x_full = $signed(48'({raw_ff, 16'h0000})) - $signed(48'(dc_new));

      y4     = (41'(x_ff) + 41'sd2048) >>> 12;
      y4_mag = (y4 < 0) ? -y4 : y4;

      sum_wide   = 65'(sum_ff) + 65'(prod_ff[63:0]);
      sum_new    = sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
      tally_new  = (tally_ff == {TALLY_BITS{1'b1}}) ? tally_ff : tally_ff + 1'b1;
      tally_wide = 32'(tally_new);

      div_t  = {rem_ff, num_ff[63]};
      div_ge = (div_t >= {1'b0, den_ff});

      root_bit = root_ff + bit_ff;
      r100     = (41'(root_ff[31:0]) << 6) + (41'(root_ff[31:0]) << 5) + (41'(root_ff[31:0]) << 2);

      e_shift = 6'(e_ff) + 6'd20;
      centi   = (v_ff + (64'd1 << (e_shift - 6'd1))) >> e_shift;

      mm     = prod_ff[63:0] >> 30;
      logval = {lexp_ff, f_ff};

      lvl_rnd = (prod_ff + 73'sd2147483648) >>> 32;
      lvl     = lvl_rnd[19:0] + $signed(20'(cfg.ref_level_deci_db));

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               raw_in   = q_item.sample;
               last_in  = q_item.window_last;
               state_in = ST_DC;
            end
         end
         ST_DC: begin
            mul_a    = $signed(41'(dc_ff));
            mul_b    = $signed(DC_KEEP);
            state_in = ST_X;
         end
         ST_X: begin
            dc_in    = dc_new;
            x_in     = x_full[39:0];
            sec_in   = '0;
            state_in = ST_B0;
         end
         ST_B0: begin
            mul_a    = 41'(x_ff);
            mul_b    = coef(2'(sec_ff), TAP_B0);
            state_in = ST_Y;
         end
         ST_Y: begin
            y_in     = sat40(q22 + z0_ext);
            mul_a    = 41'(x_ff);
            mul_b    = coef(2'(sec_ff), TAP_B1);
            state_in = ST_C1;
         end
         ST_C1: begin
            acc_in   = q22 + z1_ext;
            mul_a    = 41'(y_ff);
            mul_b    = coef(2'(sec_ff), TAP_A1);
            state_in = ST_C3;
         end
         ST_C3: begin
            z1n_in   = sat40(acc_ff - q22);
            mul_a    = 41'(x_ff);
            mul_b    = coef(2'(sec_ff), TAP_B2);
            state_in = ST_C2;
         end
         ST_C2: begin
            acc_in   = q22;
            mul_a    = 41'(y_ff);
            mul_b    = coef(2'(sec_ff), TAP_A2);
            state_in = ST_C4;
         end
         ST_C4: begin
            for (int i = 0; i < ZDEPTH - 2; i++) begin
               z_in[i] = z_ff[i+2];
            end
            z_in[ZDEPTH-2] = z1n_ff;
            z_in[ZDEPTH-1] = sat40(acc_ff - q22);
            x_in = y_ff;
            if (sec_ff == SEC_W'(SECTIONS - 1)) begin
               state_in = ST_SQ;
            end else begin
               sec_in   = sec_ff + 1'b1;
               state_in = ST_B0;
            end
         end
         ST_SQ: begin
            mul_a    = y4_mag;
            mul_b    = y4_mag[31:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (last_ff) begin
               num_in   = sum_new;
               den_in   = (tally_new == '0) ? TALLY_BITS'(1) : tally_new;
               rem_in   = '0;
               cnt_in   = '0;
               count_in = (tally_wide > 32'(COUNT_MAX)) ? 17'(COUNT_MAX) : tally_wide[16:0];
               sum_in   = '0;
               tally_in = '0;
               dc_in    = cfg.wide_adc_mode ? 32'h1000_0000 : 32'h0800_0000;
               state_in = ST_DIV;
            end else begin
               sum_in   = sum_new;
               tally_in = tally_new;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? TALLY_BITS'(div_t - {1'b0, den_ff}) : div_t[TALLY_BITS-1:0];
            num_in = {num_ff[62:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               e_in     = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (e_ff < 4'd12 && num_ff[63:61] == 3'b000) begin
               num_in = num_ff << 2;
               e_in   = e_ff + 1'b1;
            end else begin
               root_in  = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (num_ff >= root_bit) begin
               num_in  = num_ff - root_bit;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               state_in = ST_R100;
            end
         end
         ST_R100: begin
            mul_a    = $signed(r100);
            mul_b    = $signed(32'(cfg.slope_q16));
            state_in = ST_V;
         end
         ST_V: begin
            v_in     = prod_ff[63:0];
            state_in = ST_CENTI;
         end
         ST_CENTI: begin
            rms_in   = (centi > 64'hF_FFFF) ? 20'hF_FFFF : centi[19:0];
            level_in = '0;
            if (centi > 64'd5 && cfg.ref_rms_centi_mv != '0) begin
               lv_in    = v_ff;
               cnt_in   = '0;
               pass_in  = 1'b0;
               state_in = ST_LNORM;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_LNORM: begin
            if (!lv_ff[63]) begin
               lv_in  = lv_ff << 1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               m_in     = lv_ff[63:33];
               lexp_in  = 6'd63 - cnt_ff;
               f_in     = '0;
               cnt_in   = '0;
               state_in = ST_LMUL;
            end
         end
         ST_LMUL: begin
            mul_a    = $signed(41'(m_ff));
            mul_b    = $signed(32'(m_ff));
            state_in = ST_LSTEP;
         end
         ST_LSTEP: begin
            f_in   = {f_ff[14:0], mm[31]};
            m_in   = mm[31] ? mm[31:1] : mm[30:0];
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff == 6'd15) ? ST_LNEXT : ST_LMUL;
         end
         ST_LNEXT: begin
            if (!pass_ff) begin
               lacc_in  = $signed(25'(logval)) - $signed(25'(e_shift) << 16);
               lv_in    = 64'(cfg.ref_rms_centi_mv);
               cnt_in   = '0;
               pass_in  = 1'b1;
               state_in = ST_LNORM;
            end else begin
               lacc_in  = lacc_ff - $signed(25'(logval));
               state_in = ST_LVL;
            end
         end
         ST_LVL: begin
            mul_a    = 41'(lacc_ff);
            mul_b    = $signed(DB_PER_LOG2_Q16);
            state_in = ST_LVL2;
         end
         ST_LVL2: begin
            if (lvl > 20'sd2000) begin
               level_in = 12'sd2000;
            end else if (lvl < -20'sd2000) begin
               level_in = -12'sd2000;
            end else begin
               level_in = lvl[11:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_rms_in   = rms_ff;
               out_level_in = level_ff;
               out_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dc_ff        <= 32'h0800_0000;
         sum_ff       <= '0;
         tally_ff     <= '0;
         for (int i = 0; i < ZDEPTH; i++) begin
            z_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dc_ff        <= dc_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         z_ff         <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff       <= raw_in;
      last_ff      <= last_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      acc_ff       <= acc_in;
      z1n_ff       <= z1n_in;
      sec_ff       <= sec_in;
      prod_ff      <= mul_a * mul_b;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      e_ff         <= e_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      v_ff         <= v_in;
      lv_ff        <= lv_in;
      m_ff         <= m_in;
      f_ff         <= f_in;
      lexp_ff      <= lexp_in;
      pass_ff      <= pass_in;
      lacc_ff      <= lacc_in;
      rms_ff       <= rms_in;
      level_ff     <= level_in;
      count_ff     <= count_in;
      out_rms_ff   <= out_rms_in;
      out_level_ff <= out_level_in;
      out_count_ff <= out_count_in;
   end

`ifndef SYNTHESIS
   a_tally_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && !last_ff) |=> (tally_ff != '0))
      else $error("sample tally did not advance");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && last_ff) |=> (sum_ff == '0 && tally_ff == '0))
      else $error("window sums not cleared at window end");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> $onehot(bit_ff))
      else $error("square root bit lost");

   a_log_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LNORM) |-> (lv_ff != '0))
      else $error("logarithm of zero");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_level_ff <= 12'sd2000 && out_level_ff >= -12'sd2000))
      else $error("level outside saturation range");
`endif

endmodule

>>> design/a_weighted_sound_level_meter_top.sv
// Channel  | Handshake             | Payload
// req      | req_valid, req_stall  | req_sample, req_window_last
// rsp      | rsp_valid, rsp_stall  | rsp_rms_centi_mv, rsp_level_deci_db, rsp_window_count
// csr      | csr_write             | csr_index, csr_data
//
// An item that does not end a window passes through the tracker, the three biquads and the square
// in turn, all on the shared 41x32 multiplier.
// An item that ends a window adds 64 divide steps, up to 12 scaling steps, 32 square root
// steps and two logarithms, each made of normalizing and squaring steps.
// Reset is synchronous and restores the registers, tracker, filter state and sums at once.
// Two items queue at the input, and one result waits in the output register.
module a_weighted_sound_level_meter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [12:0]        req_sample,
   input  logic               req_window_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_rms_centi_mv,
   output logic signed [11:0] rsp_level_deci_db,
   output logic [16:0]        rsp_window_count,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_data
);
   import awslm_pkg::*;

   awslm_cfg_type  cfg_ff, cfg_in;
   awslm_item_type req_item;
   awslm_item_type q_item;
   logic           q_valid;
   logic           q_pop;

   assign req_item.sample      = req_sample[SAMPLE_BITS-1:0];
   assign req_item.window_last = req_window_last;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDE_ADC_MODE:     cfg_in.wide_adc_mode     = csr_data[0];
            CSR_SLOPE_Q16:         cfg_in.slope_q16         = csr_data[17:0];
            CSR_REF_RMS_CENTI_MV:  cfg_in.ref_rms_centi_mv  = csr_data[19:0];
            CSR_REF_LEVEL_DECI_DB: cfg_in.ref_level_deci_db = csr_data[10:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide_adc_mode     <= 1'b0;
         cfg_ff.slope_q16         <= 18'd52429;
         cfg_ff.ref_rms_centi_mv  <= 20'd16600;
         cfg_ff.ref_level_deci_db <= 11'd940;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   awslm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   awslm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rms_centi_mv  (rsp_rms_centi_mv),
      .rsp_level_deci_db (rsp_level_deci_db),
      .rsp_window_count  (rsp_window_count)
   );

endmodule

>>> tb/tb_a_weighted_sound_level_meter_top.sv
module tb_a_weighted_sound_level_meter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import awslm_pkg::*;

   localparam int TAIL_CYCLES = 500;
   localparam int TALLY_LIMIT = 131071;

   typedef struct {
      logic [19:0]        rms;
      logic signed [11:0] level;
      logic [16:0]        count;
   } reading_type;

   typedef struct {
      bit          is_write;
      logic [1:0]  index;
      logic [19:0] data;
      logic [12:0] sample;
      bit          last;
      bit          typed;
      reading_type reading;
   } row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [12:0]        req_sample = '0;
   logic               req_window_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [19:0]        rsp_rms_centi_mv;
   logic signed [11:0] rsp_level_deci_db;
   logic [16:0]        rsp_window_count;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [19:0]        csr_data = '0;

   a_weighted_sound_level_meter_top dut (.*);

   localparam int COEFS [3][5] = '{
      '{2219177, -4438354, 2219177, -8321025, 4126994},
      '{4194304, -8388608, 4194304, -7153427, 3003071},
      '{4194304, 8388608, 4194304, 3445889, 707755}};

   bit          mode_wide;
   bit [17:0]   slope;
   bit [19:0]   cal_rms;
   bit [10:0]   cal_level;
   bit [31:0]   tracker;
   longint      delay_line [6];
   longint unsigned energy;
   int          tally;

   reading_type pending_readings [$];
   bit          failed = 1'b0;
   int          burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip40(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
   endfunction

   function automatic longint scale(longint v, int c);
      return round_shift(v * longint'(c), 22);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint log2_q16(longint unsigned v);
      int n;
      longint unsigned m;
      longint f;
      n = 63;
      f = 0;
      while (((v >> n) & 1) == 0 && n > 0) n--;
      m = (n > 30) ? v >> (n - 30) : v << (30 - n);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         f = f << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            f = f | 1;
         end
      end
      return (longint'(n) <<< 16) + f;
   endfunction

   function automatic void meter_reset();
      mode_wide = 1'b0;
      slope = 18'd52429;
      cal_rms = 20'd16600;
      cal_level = 11'd940;
      foreach (delay_line[i]) delay_line[i] = 0;
      energy = 0;
      tally = 0;
      tracker = 32'd2048 << 16;
   endfunction

   function automatic bit meter_step(logic [12:0] sample, bit last, output reading_type rd);
      longint unsigned raw, t, sq, mean, r, v, centi;
      longint x, y, z1, z2, y4, d, lvl;
      int e;
      raw = sample;
      rd = '{default: '0};
      t = (longint'(tracker) * 64'd16775538 + (raw << 16) * 64'd1678 + (64'd1 << 23)) >> 24;
      tracker = t[31:0];
      x = longint'(raw << 16) - longint'(tracker);
      for (int k = 0; k < 3; k++) begin
         y = clip40(scale(x, COEFS[k][0]) + delay_line[2*k]);
         z1 = clip40(scale(x, COEFS[k][1]) - scale(y, COEFS[k][3]) + delay_line[2*k+1]);
         z2 = clip40(scale(x, COEFS[k][2]) - scale(y, COEFS[k][4]));
         delay_line[2*k] = z1;
         delay_line[2*k+1] = z2;
         x = y;
      end
      y4 = round_shift(x, 12);
      if (y4 < 0) y4 = -y4;
      sq = longint'(y4) * longint'(y4);
      energy = (energy > ~64'd0 - sq) ? ~64'd0 : energy + sq;
      if (tally < TALLY_LIMIT) tally++;
      if (!last) return 1'b0;
      mean = energy / longint'(tally != 0 ? tally : 1);
      e = 0;
      while (e < 12 && (mean >> 61) == 0) begin
         mean = mean << 2;
         e++;
      end
      r = root64(mean);
      v = r * longint'(slope) * 64'd100;
      centi = (v + (64'd1 << (19 + e))) >> (20 + e);
      lvl = 0;
      if (centi > 5 && cal_rms != 0) begin
         d = log2_q16(v) - (longint'(20 + e) <<< 16) - log2_q16(longint'(cal_rms));
         lvl = round_shift(d * 64'sd3945660, 32) + longint'(cal_level);
         if (lvl > 2000) lvl = 2000;
         if (lvl < -2000) lvl = -2000;
      end
      rd.rms = (centi > 64'hFFFFF) ? 20'hFFFFF : centi[19:0];
      rd.level = lvl[11:0];
      rd.count = tally[16:0];
      energy = 0;
      tally = 0;
      tracker = (mode_wide ? 32'd4096 : 32'd2048) << 16;
      return 1'b1;
   endfunction

   task automatic write_reg(logic [1:0] index, logic [19:0] data);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_WIDE_ADC_MODE:     mode_wide = data[0];
         CSR_SLOPE_Q16:         slope = data[17:0];
         CSR_REF_RMS_CENTI_MV:  cal_rms = data[19:0];
         CSR_REF_LEVEL_DECI_DB: cal_level = data[10:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(logic [12:0] sample, bit last, bit typed, reading_type fixed);
      reading_type rd;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_sample <= sample;
      req_window_last <= last;
      do @(posedge clock); while (req_stall);
      if (meter_step(sample, last, rd)) pending_readings.push_back(typed ? fixed : rd);
   endtask

   function automatic logic [12:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 13'd0;
         1: return 13'h1FFF;
         2: return 13'd2048 + 13'($urandom_range(0, 64)) - 13'd32;
         default: return 13'($urandom);
      endcase
   endfunction

   function automatic logic [19:0] pick_value(int top);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 20'(top);
         default: return 20'($urandom_range(0, top));
      endcase
   endfunction

   localparam reading_type NONE = '{rms: '0, level: '0, count: '0};

   row_type directed [30] = '{
      '{0, 0, 0, 13'd2048, 1, 1, '{rms: 20'd0, level: 12'sd0, count: 17'd1}},
      '{0, 0, 0, 13'd0, 0, 0, NONE},
      '{0, 0, 0, 13'h1FFF, 0, 0, NONE},
      '{0, 0, 0, 13'd0, 1, 0, NONE},
      '{1, CSR_REF_RMS_CENTI_MV, 20'd0, 0, 0, 0, NONE},
      '{0, 0, 0, 13'h1FFF, 0, 0, NONE},
      '{0, 0, 0, 13'd0, 1, 0, NONE},
      '{1, CSR_REF_RMS_CENTI_MV, 20'hFFFFF, 0, 0, 0, NONE},
      '{1, CSR_REF_LEVEL_DECI_DB, 20'd2047, 0, 0, 0, NONE},
      '{1, CSR_SLOPE_Q16, 20'd262143, 0, 0, 0, NONE},
      '{0, 0, 0, 13'h1FFF, 0, 0, NONE},
      '{0, 0, 0, 13'd0, 0, 0, NONE},
      '{0, 0, 0, 13'h1FFF, 0, 0, NONE},
      '{0, 0, 0, 13'd0, 1, 0, NONE},
      '{1, CSR_SLOPE_Q16, 20'd0, 0, 0, 0, NONE},
      '{0, 0, 0, 13'h1FFF, 0, 0, NONE},
      '{0, 0, 0, 13'd0, 1, 1, '{rms: 20'd0, level: 12'sd0, count: 17'd2}},
      '{1, CSR_WIDE_ADC_MODE, 20'd1, 0, 0, 0, NONE},
      '{1, CSR_SLOPE_Q16, 20'd52429, 0, 0, 0, NONE},
      '{1, CSR_REF_LEVEL_DECI_DB, 20'd0, 0, 0, 0, NONE},
      '{1, CSR_REF_RMS_CENTI_MV, 20'd1, 0, 0, 0, NONE},
      '{0, 0, 0, 13'd4096, 1, 0, NONE},
      '{0, 0, 0, 13'd4096, 1, 0, NONE},
      '{0, 0, 0, 13'h1FFF, 0, 0, NONE},
      '{0, 0, 0, 13'd4095, 1, 0, NONE},
      '{1, CSR_WIDE_ADC_MODE, 20'd0, 0, 0, 0, NONE},
      '{1, CSR_REF_RMS_CENTI_MV, 20'd16600, 0, 0, 0, NONE},
      '{1, CSR_REF_LEVEL_DECI_DB, 20'd940, 0, 0, 0, NONE},
      '{0, 0, 0, 13'd2048, 1, 0, NONE},
      '{0, 0, 0, 13'd100, 1, 0, NONE}};

   initial begin
      int left;
      meter_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            write_reg(directed[i].index, directed[i].data);
         end else begin
            send_sample(directed[i].sample, directed[i].last, directed[i].typed,
                        directed[i].reading);
         end
      end
      for (int phase = 0; phase < 6; phase++) begin
         burst_left = 0;
         write_reg(CSR_WIDE_ADC_MODE, 20'($urandom_range(0, 1)));
         write_reg(CSR_SLOPE_Q16, pick_value(262143));
         write_reg(CSR_REF_RMS_CENTI_MV, pick_value(1048575));
         write_reg(CSR_REF_LEVEL_DECI_DB, pick_value(2047));
         for (int n = 0; n < 165; n++) begin
            if (left <= 0) left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                               : $urandom_range(1, 24);
            left--;
            send_sample(pick_sample(), left == 0, 1'b0, NONE);
         end
      end
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   int stall_mode = 0;
   int stall_hold = 0;

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected item: rms %0d level %0d count %0d",
                   rsp_rms_centi_mv, rsp_level_deci_db, rsp_window_count);
            failed = 1'b1;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_rms_centi_mv !== want.rms) begin
               $error("rms_centi_mv expected %0d actual %0d", want.rms, rsp_rms_centi_mv);
               failed = 1'b1;
            end
            if (rsp_level_deci_db !== want.level) begin
               $error("level_deci_db expected %0d actual %0d", want.level, rsp_level_deci_db);
               failed = 1'b1;
            end
            if (rsp_window_count !== want.count) begin
               $error("window_count expected %0d actual %0d", want.count, rsp_window_count);
               failed = 1'b1;
            end
         end
      end
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_hold <= $urandom_range(50, 400);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   initial begin
      #200ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
